// ===== sv/hpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// hpcf_pkg
// shared types and constants of the hashed page counting filter
// ----------------------------------------------------------------------------
package hpcf_pkg;

  localparam int HASH_BITS_DEF     = 12;
  localparam int MAX_PAGE_SPAN_DEF = 4096;

  localparam int ADDR_W     = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
  localparam int COUNT_W    = 8;

  // fibonacci hashing multiplier, split for the 32x32 multiplier
  localparam logic [63:0] HASH_MULT    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [31:0] HASH_MULT_LO = HASH_MULT[31:0];
  localparam logic [31:0] HASH_MULT_HI = HASH_MULT[63:32];

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_PROTECT   = 2'd0,
    FUNC_UNPROTECT = 2'd1,
    FUNC_PROBE     = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    STAT_APPLIED   = 3'd0,
    STAT_DISABLED  = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_TOO_LARGE = 3'd3,
    STAT_PROBE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DECIDE,
    ST_PROBE,
    ST_READ,
    ST_WRITE,
    ST_RESULT
  } state_t;

  // saturating counter update, 255 is sticky
  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v,
                                              input logic up);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v != COUNT_MAX) begin
      if (up) begin
        r = v + COUNT_W'(1);
      end else if (v != '0) begin
        r = v - COUNT_W'(1);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/hashed_page_counting_filter.sv =====
// ----------------------------------------------------------------------------
// hashed_page_counting_filter
// page counting filter: 8-bit saturating counters indexed by a fibonacci hash
// ----------------------------------------------------------------------------
// sequence: a request runs PREP, MUL1, MUL2, MUL3 and DECIDE; a probe then reads
//   in PROBE, an applied range walks READ and WRITE per page, all end in RESULT
// throughput: one request at a time; each page costs one read and one write
//   of the counter ram, the hash start takes multiply and accumulate steps in
//   PREP, MUL1, MUL2 and MUL3
// reset: rst clears control state and filter_enabled, then a clearing pass
//   writes zero to all 2^HASH_BITS counters, one a cycle; no request is taken
//   until it ends, configuration writes are taken throughout
// ----------------------------------------------------------------------------
module hashed_page_counting_filter
  import hpcf_pkg::*;
#(
  parameter int HASH_BITS     = HASH_BITS_DEF,
  parameter int MAX_PAGE_SPAN = MAX_PAGE_SPAN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration: filter_enabled
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,
  // requests
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // base_address [63:0], size_bytes [127:64]
  input  logic [1:0]   s_axis_tuser,   // func [1:0]
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,   // probe_hit [0], probe_count [8:1], zero pad
  output logic [2:0]   m_axis_tuser    // status [2:0]
);

  localparam int DEPTH = 1 << HASH_BITS;
  localparam int CNT_W = $clog2(MAX_PAGE_SPAN + 1);
  localparam logic [PAGE_W-1:0] SPAN_LIMIT = PAGE_W'(MAX_PAGE_SPAN);

  // control
  state_t state, state_next;
  logic [HASH_BITS-1:0] clr_addr;
  logic [CNT_W-1:0] cnt;
  logic filter_enabled;

  // request held for the whole operation
  func_t             op_func;
  logic [ADDR_W-1:0] op_base;
  logic [ADDR_W-1:0] op_size;

  // range checks, worked out over the multiplier steps
  logic [ADDR_W-1:0] end_addr;
  logic [PAGE_W-1:0] span;
  logic              size_zero;
  logic              too_big;

  // hash product of the current page, advanced by one multiplier per page
  logic [63:0] mult;
  logic [63:0] acc;
  logic [31:0] mult_a, mult_b;
  logic [HASH_BITS-1:0] hash_idx;
  logic [HASH_BITS-1:0] walk_addr;

  // result waiting for the output register
  status_t res_status;
  logic [COUNT_W-1:0] res_count;

  // output register
  logic out_valid;
  status_t out_status;
  logic out_hit;
  logic [COUNT_W-1:0] out_count;

  // ram port
  logic ram_we, ram_re;
  logic [HASH_BITS-1:0] ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  logic in_take, out_free, is_range, is_up;

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign is_range = (op_func == FUNC_PROTECT) || (op_func == FUNC_UNPROTECT);
  assign is_up    = (op_func == FUNC_PROTECT);
  assign hash_idx = acc[63 -: HASH_BITS];

  // page number halves: low 32 bits and the upper bits, zero extended
  always_comb begin
    case (state)
      ST_PREP: begin
        mult_a = op_base[PAGE_SHIFT +: 32];
        mult_b = HASH_MULT_LO;
      end
      ST_MUL1: begin
        mult_a = op_base[PAGE_SHIFT +: 32];
        mult_b = HASH_MULT_HI;
      end
      ST_MUL2: begin
        mult_a = 32'(op_base[ADDR_W-1:PAGE_SHIFT+32]);
        mult_b = HASH_MULT_LO;
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr == HASH_BITS'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_take) state_next = ST_PREP;
      ST_PREP:   state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!is_range) begin
          state_next = ST_PROBE;
        end else if (!filter_enabled || size_zero || too_big) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_PROBE:  state_next = ST_RESULT;
      ST_READ:   state_next = ST_WRITE;
      ST_WRITE:  state_next = (cnt == '0) ? ST_RESULT : ST_READ;
      ST_RESULT: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // ram and handshake outputs
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = walk_addr;
    ram_wdata     = bump(ram_rdata, is_up);
    ram_re        = 1'b0;
    ram_raddr     = hash_idx;
    s_axis_tready = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_DECIDE: ram_re = !is_range;
      ST_READ:   ram_re = 1'b1;
      ST_WRITE:  ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      filter_enabled <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + HASH_BITS'(1);
      end
      if (cfg_valid && cfg_ready) begin
        filter_enabled <= cfg_data;
      end
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          op_func <= func_t'(s_axis_tuser);
          op_base <= s_axis_tdata[63:0];
          op_size <= s_axis_tdata[127:64];
        end
      end
      ST_PREP: begin
        mult      <= mult_a * mult_b;
        end_addr  <= op_base + op_size - ADDR_W'(1);
        size_zero <= (op_size == '0);
      end
      ST_MUL1: begin
        mult <= mult_a * mult_b;
        acc  <= mult;
        span <= end_addr[ADDR_W-1:PAGE_SHIFT] - op_base[ADDR_W-1:PAGE_SHIFT];
      end
      ST_MUL2: begin
        mult    <= mult_a * mult_b;
        acc     <= acc + {mult[31:0], 32'h0};
        // an end that wraps past the top of the address space lands below the start
        too_big <= (span > SPAN_LIMIT) ||
                   (end_addr[ADDR_W-1:PAGE_SHIFT] < op_base[ADDR_W-1:PAGE_SHIFT]);
      end
      ST_MUL3: acc <= acc + {mult[31:0], 32'h0};
      ST_DECIDE: begin
        cnt       <= span[CNT_W-1:0];
        res_count <= '0;
        if (!filter_enabled) begin
          res_status <= STAT_DISABLED;
        end else if (size_zero) begin
          res_status <= STAT_EMPTY;
        end else if (too_big) begin
          res_status <= STAT_TOO_LARGE;
        end else begin
          res_status <= STAT_APPLIED;
        end
      end
      ST_PROBE: begin
        res_status <= STAT_PROBE;
        res_count  <= ram_rdata;
      end
      ST_READ: walk_addr <= hash_idx;
      ST_WRITE: begin
        // next page: product moves on by one multiplier
        acc <= acc + HASH_MULT;
        cnt <= cnt - CNT_W'(1);
      end
      ST_RESULT: begin
        if (out_free) begin
          out_status <= res_status;
          out_count  <= res_count;
          out_hit    <= (res_count != '0);
        end
      end
      default: begin
      end
    endcase
  end

  hpcf_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'h0, out_count, out_hit};
  assign m_axis_tuser  = out_status;

  // read-modify-write never overlaps a read with a write
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("counter ram read and written in one cycle");

  // a counter write always follows its own read
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_WRITE |-> $past(state) == ST_READ)
    else $error("counter write without a preceding read");

  // hit flag agrees with the count, non-probe results carry no count
  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hit == (out_count != '0)) &&
                  ((out_status == STAT_PROBE) || (out_count == '0)))
    else $error("inconsistent result fields");

  // a finished result waits while the output register is still held
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_RESULT && out_valid && !m_axis_tready |=> state == ST_RESULT)
    else $error("result dropped while output held");

endmodule

// ===== sv/hpcf_ram.sv =====
// ----------------------------------------------------------------------------
// hpcf_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module hpcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
